// File: rtl/core/wsf_pkg.sv
// ----------------------------------------------------------------------------
// wsf_pkg
// Shared types and constants for the wake-up strobe framer.
// ----------------------------------------------------------------------------
package wsf_pkg;

	// frame type codes
	localparam logic [7:0] TYPE_STROBE    = 8'd1;
	localparam logic [7:0] TYPE_SACK      = 8'd2;
	localparam logic [7:0] TYPE_BROADCAST = 8'd3;

	// sent counter wraps to zero above this
	localparam logic [7:0] STROBE_SENT_LIMIT = 8'd16;

	// item kinds
	localparam logic [1:0] KIND_STROBE    = 2'd0;
	localparam logic [1:0] KIND_ACK       = 2'd1;
	localparam logic [1:0] KIND_BROADCAST = 2'd2;
	localparam logic [1:0] KIND_PARSE     = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BC_NO_ACK   = 3'd1;
	localparam logic [2:0] ST_BC_LAST     = 3'd2;
	localparam logic [2:0] ST_BAD_ADDR    = 3'd3;
	localparam logic [2:0] ST_COLL_SAME   = 3'd4;
	localparam logic [2:0] ST_COLL_DIFF   = 3'd5;
	localparam logic [2:0] ST_BAD_ACK     = 3'd6;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd7;

	// frame lengths
	localparam logic [2:0] LEN_NONE   = 3'd0;
	localparam logic [2:0] LEN_SACK   = 3'd3;
	localparam logic [2:0] LEN_STROBE = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_OWN_ID     = 3'd0;
	localparam logic [2:0] REG_POWERUP    = 3'd1;
	localparam logic [2:0] REG_WAKE_MIN   = 3'd2;
	localparam logic [2:0] REG_WAKE_ADV   = 3'd3;
	localparam logic [2:0] REG_SACK_OVH   = 3'd4;
	localparam logic [2:0] REG_STROBE_PER = 3'd5;
	localparam logic [2:0] REG_STROBE_MAX = 3'd6;
	localparam logic [2:0] REG_BC_MAX     = 3'd7;

	// register reset values
	localparam logic [15:0] RST_POWERUP    = 16'd1000;
	localparam logic [15:0] RST_WAKE_MIN   = 16'd100;
	localparam logic [15:0] RST_WAKE_ADV   = 16'd20;
	localparam logic [15:0] RST_SACK_OVH   = 16'd4;
	localparam logic [7:0]  RST_STROBE_PER = 8'd5;
	localparam logic [7:0]  RST_STROBE_MAX = 8'd10;
	localparam logic [7:0]  RST_BC_MAX     = 8'd10;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] now_tick;
		logic [15:0] dest_id;
		logic        tx_pending;
		logic [7:0]  rx_type;
		logic [15:0] rx_id;
		logic [7:0]  rx_count;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  frame_len;
		logic [7:0]  out_type;
		logic [15:0] out_id;
		logic [7:0]  out_count;
		logic [31:0] delay_ms;
		logic [2:0]  status;
	} out_item_t;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] wake;
		logic [7:0]  sent;
	} peer_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_DIV,
		S_MUL,
		S_LOOP,
		S_WR,
		S_DONE
	} fsm_t;

endpackage

// File: rtl/core/wakeup_strobe_framer.sv
// ----------------------------------------------------------------------------
// wakeup_strobe_framer
// Wake-up framer: builds strobes, acks and broadcasts, parses received frames,
// and keeps a peer table in RAM to predict the first strobe's delay.
// ----------------------------------------------------------------------------
//  channel | signals                         | beat
//  in      | in_valid/in_ready, in_data      | one request item
//  out     | out_valid/out_ready, out_data   | one result item
//  cfg     | cfg_valid/cfg_ready, index/data | one register write
//
//  Ack, broadcast and most parse beats go from S_IDLE through S_DONE to the
//  output register. Strobe and received-ack beats scan the peer table with
//  S_RD and S_CHK per entry, then write back in S_WR if an entry matches or
//  (strobes) a slot is free. Delay prediction adds S_DIV, S_MUL and S_LOOP.
//  Reset sets control registers, clears entry valid bits; no clearing pass.
//  A new beat is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module wakeup_strobe_framer import wsf_pkg::*; #(
	parameter int TABLE_ENTRIES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

	// configuration registers
	logic [15:0] own_id_q, powerup_q, wake_min_q, wake_adv_q, sack_ovh_q;
	logic [7:0]  strobe_per_q, strobe_max_q, bc_max_q;

	// block state
	logic [7:0]  strobe_cd_q, bc_cd_q;
	logic        got_bc_q;
	logic [31:0] ack_delay_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	fsm_t        state_q, state_d;
	in_item_t    item_q;
	out_item_t   res_q;
	logic        sack_op_q;
	logic [AW-1:0] ptr_q, sel_addr_q;
	peer_entry_t sel_q;
	logic        slot_q;
	logic [31:0] prod_q, x_q;

	// RAM and divider
	peer_entry_t rd_entry, rdata, wdata;
	logic        ram_we;
	logic        div_start, div_done;
	logic [31:0] div_quot;
	logic [15:0] period;

	logic        in_fire, go_done, scan_now, chk_hit, chk_free, chk_sack;
	logic [15:0] ack_prod;
	logic [31:0] ack_val, loop_d;
	logic [7:0]  sent_next;
	out_item_t   res_imm;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign period    = (powerup_q == 16'd0) ? 16'd1 : powerup_q;

	wsf_ram #(.WIDTH($bits(peer_entry_t)), .DEPTH(TABLE_ENTRIES), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sel_addr_q),
		.wdata (wdata),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	// divider starts on the entry being checked
	wsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (item_q.now_tick - rd_entry.wake),
		.divisor  (period),
		.done     (div_done),
		.quot     (div_quot)
	);

	// entries never written read as a free slot
	assign rd_entry = valid_q[ptr_q] ? rdata : '0;
	assign chk_hit  = (rd_entry.id == item_q.dest_id) && (rd_entry.wake != 32'd0);
	assign chk_free = (rd_entry.id == 16'd0);
	assign chk_sack = (rd_entry.id == item_q.dest_id);

	// ack delay from a received countdown
	assign ack_prod = in_data.rx_count * strobe_per_q;
	assign ack_val  = (in_data.rx_count == 8'd0 || ack_prod <= sack_ovh_q) ? 32'd0
		: {16'd0, 16'(ack_prod - sack_ovh_q)};

	// one step of the prediction loop
	assign loop_d   = 32'(x_q - {16'd0, wake_min_q});
	assign sent_next = (sel_q.sent > STROBE_SENT_LIMIT) ? 8'd0 : 8'(sel_q.sent + 8'd1);

	// write-back data
	always_comb begin
		if (sack_op_q) begin
			wdata = '{id: sel_q.id, wake: item_q.now_tick, sent: 8'd0};
		end else begin
			wdata = '{id: item_q.dest_id, wake: sel_q.wake, sent: sent_next};
		end
	end

	// result of the accepted beat, and whether it needs table work
	always_comb begin
		res_imm  = '0;
		scan_now = 1'b0;
		case (in_data.kind)
			KIND_STROBE: begin
				res_imm.frame_len = LEN_STROBE;
				res_imm.out_type  = TYPE_STROBE;
				res_imm.out_id    = in_data.dest_id;
				res_imm.out_count = strobe_cd_q;
				scan_now          = 1'b1;
			end
			KIND_ACK: begin
				res_imm.delay_ms = ack_delay_q;
				if (got_bc_q) begin
					res_imm.status = ST_BC_NO_ACK;
				end else begin
					res_imm.frame_len = LEN_SACK;
					res_imm.out_type  = TYPE_SACK;
					res_imm.out_id    = own_id_q;
				end
			end
			KIND_BROADCAST: begin
				res_imm.frame_len = LEN_STROBE;
				res_imm.out_type  = TYPE_BROADCAST;
				res_imm.out_count = bc_cd_q;
				if (bc_cd_q == 8'd0) begin
					res_imm.status = ST_BC_LAST;
				end
			end
			default: begin
				if (in_data.rx_type == TYPE_STROBE) begin
					if (in_data.rx_id != own_id_q) begin
						if (!in_data.tx_pending) begin
							res_imm.status = ST_BAD_ADDR;
						end else if (in_data.rx_id == in_data.dest_id) begin
							res_imm.status = ST_COLL_SAME;
						end else begin
							res_imm.status = ST_COLL_DIFF;
						end
					end
				end else if (in_data.rx_type == TYPE_SACK) begin
					if (in_data.rx_id == in_data.dest_id) begin
						scan_now = 1'b1;
					end else begin
						res_imm.status = ST_BAD_ACK;
					end
				end else if (in_data.rx_type != TYPE_BROADCAST) begin
					res_imm.status = ST_UNSUPPORTED;
				end
			end
		endcase
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		div_start = 1'b0;
		go_done   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = scan_now ? S_RD : S_DONE;
				end
			end
			S_RD: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sack_op_q) begin
					if (chk_sack) begin
						state_d = S_WR;
					end else if (ptr_q == LAST_ADDR) begin
						state_d = S_DONE;
					end else begin
						state_d = S_RD;
					end
				end else if (chk_hit) begin
					if (rd_entry.sent == 8'd0) begin
						div_start = 1'b1;
						state_d   = S_DIV;
					end else begin
						state_d = S_WR;
					end
				end else if (ptr_q == LAST_ADDR) begin
					state_d = (slot_q || chk_free) ? S_WR : S_DONE;
				end else begin
					state_d = S_RD;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_LOOP;
			end
			S_LOOP: begin
				if (x_q > {16'd0, wake_min_q}) begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				ram_we  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid || out_ready) begin
					go_done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid    <= 1'b0;
			own_id_q     <= '0;
			powerup_q    <= RST_POWERUP;
			wake_min_q   <= RST_WAKE_MIN;
			wake_adv_q   <= RST_WAKE_ADV;
			sack_ovh_q   <= RST_SACK_OVH;
			strobe_per_q <= RST_STROBE_PER;
			strobe_max_q <= RST_STROBE_MAX;
			bc_max_q     <= RST_BC_MAX;
			strobe_cd_q  <= RST_STROBE_MAX;
			bc_cd_q      <= RST_BC_MAX;
			got_bc_q     <= 1'b0;
			ack_delay_q  <= '0;
			valid_q      <= '0;
			slot_q       <= 1'b0;
			sack_op_q    <= 1'b0;
			ptr_q        <= '0;
		end else begin
			state_q <= state_d;

			// register writes
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_OWN_ID:     own_id_q     <= cfg_data;
					REG_POWERUP:    powerup_q    <= cfg_data;
					REG_WAKE_MIN:   wake_min_q   <= cfg_data;
					REG_WAKE_ADV:   wake_adv_q   <= cfg_data;
					REG_SACK_OVH:   sack_ovh_q   <= cfg_data;
					REG_STROBE_PER: strobe_per_q <= cfg_data[7:0];
					REG_STROBE_MAX: strobe_max_q <= cfg_data[7:0];
					REG_BC_MAX:     bc_max_q     <= cfg_data[7:0];
					default: ;
				endcase
			end

			// accepted beat: counters and flags
			if (in_fire) begin
				ptr_q     <= '0;
				slot_q    <= 1'b0;
				sack_op_q <= (in_data.kind == KIND_PARSE);
				case (in_data.kind)
					KIND_STROBE: begin
						strobe_cd_q <= (strobe_cd_q == 8'd0) ? strobe_max_q
							: 8'(strobe_cd_q - 8'd1);
					end
					KIND_ACK: begin
						got_bc_q    <= 1'b0;
						ack_delay_q <= '0;
					end
					KIND_BROADCAST: begin
						bc_cd_q <= (bc_cd_q == 8'd0) ? bc_max_q : 8'(bc_cd_q - 8'd1);
					end
					default: begin
						if (in_data.rx_type == TYPE_STROBE) begin
							if (in_data.rx_id == own_id_q) begin
								ack_delay_q <= ack_val;
							end
						end else if (in_data.rx_type != TYPE_SACK &&
							in_data.rx_type == TYPE_BROADCAST) begin
							got_bc_q    <= 1'b1;
							ack_delay_q <= ack_val;
						end
					end
				endcase
			end

			// table scan
			if (state_q == S_CHK) begin
				if (!sack_op_q && !chk_hit && chk_free && !slot_q) begin
					slot_q <= 1'b1;
				end
				if (ptr_q != LAST_ADDR) begin
					ptr_q <= AW'(ptr_q + AW'(1));
				end
			end

			// prediction done: countdown restarts
			if (state_q == S_LOOP && state_d == S_WR) begin
				strobe_cd_q <= strobe_max_q;
			end

			if (ram_we) begin
				valid_q[sel_addr_q] <= 1'b1;
			end

			// output register
			if (go_done) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_data;
			res_q  <= res_imm;
		end
		if (state_q == S_CHK) begin
			if (sack_op_q ? chk_sack : (chk_hit || (chk_free && !slot_q))) begin
				sel_q      <= rd_entry;
				sel_addr_q <= ptr_q;
			end
		end
		if (state_q == S_DIV && div_done) begin
			prod_q <= 32'((div_quot + 32'd1) * period);
		end
		if (state_q == S_MUL) begin
			x_q <= 32'(sel_q.wake + prod_q - item_q.now_tick);
		end
		if (state_q == S_LOOP) begin
			if (x_q > {16'd0, wake_min_q}) begin
				res_q.delay_ms <= (loop_d > {16'd0, wake_adv_q})
					? 32'(loop_d - {16'd0, wake_adv_q}) : loop_d;
			end else begin
				x_q <= 32'(x_q + {16'd0, period});
			end
		end
		if (go_done) begin
			out_data <= res_q;
		end
	end

endmodule

// File: rtl/core/wsf_ram.sv
// ----------------------------------------------------------------------------
// wsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsf_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/wsf_div.sv
// ----------------------------------------------------------------------------
// wsf_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module wsf_div import wsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quot
);

	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic [16:0] rem_sh;
	logic        fits;

	// shift in the next dividend bit and try a subtract
	assign rem_sh = {rem_q, quot[31]};
	assign fits   = (rem_sh >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quot  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(rem_sh - {1'b0, div_q}) : rem_sh[15:0];
			quot  <= {quot[30:0], fits};
		end
	end

endmodule

// File: rtl/core/wsf_checker.sv
// ----------------------------------------------------------------------------
// wsf_props
// Port-level checks on the framer's results, bound to the top level.
// ----------------------------------------------------------------------------
module wsf_props import wsf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// error statuses never come with a built frame
	a_err_noframe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK && out_data.status != ST_BC_LAST
		|-> out_data.frame_len == LEN_NONE)
		else $error("frame built with error status");

	// no frame means empty frame fields
	a_noframe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_len == LEN_NONE
		|-> out_data.out_type == 8'd0 && out_data.out_id == 16'd0 &&
			out_data.out_count == 8'd0)
		else $error("frame fields set without a frame");

	// an ack frame carries no countdown
	a_sack_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_len == LEN_SACK
		|-> out_data.out_count == 8'd0 && out_data.out_type == TYPE_SACK)
		else $error("malformed ack frame");

endmodule

bind wakeup_strobe_framer wsf_props u_wsf_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
